@@ src/rational_arithmetic_unit_defines.svh @@
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Assert that an implication holds on every clock edge outside reset.
`define RAU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an implication holds in the cycle after its antecedent.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rau_pkg.sv @@
// Package with types, codes and constants of the rational arithmetic unit.
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [2:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_REM  = 3'd2,
        KIND_MUL  = 3'd3,
        KIND_IMUL = 3'd4,
        KIND_INV  = 3'd5,
        KIND_NORM = 3'd6,
        KIND_RSVD = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t kind;
        word_t a_num;
        word_t a_den;
        word_t b_num;
        word_t b_den;
    } req_t;

    typedef struct packed {
        word_t res_num;
        word_t res_den;
        logic  div_error;
    } resp_t;

    // Divider command and status between the sequencer and the divider.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_cmd_t;

    typedef struct packed {
        logic  done;
        word_t quot;
        word_t rem;
    } div_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LCM_CHK,
        ST_GCD_STEP,
        ST_GCD_WAIT,
        ST_LCM_DIV,
        ST_LCM_DIVW,
        ST_LCM_MUL,
        ST_M1_DIV,
        ST_M1_DIVW,
        ST_M2_DIV,
        ST_M2_DIVW,
        ST_COMBINE,
        ST_REM_DIVW,
        ST_NORM_CHK,
        ST_NDIV,
        ST_NDIVW,
        ST_DDIV,
        ST_DDIVW,
        ST_NFIX,
        ST_MUL2,
        ST_DONE
    } state_t;

    // Where a gcd finishes, the sequencer continues.
    typedef enum logic [1:0] {
        GCD_FOR_LCM,
        GCD_FOR_NORM
    } gcd_use_t;

    function automatic word_t wneg(input word_t a);
        wneg = word_t'(-a);
    endfunction

endpackage

@@ src/rau_divider.sv @@
// Restoring divider with C truncating semantics, one quotient bit per cycle.
module rau_divider
    import rau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_cmd_t cmd,
    output div_sts_t sts
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] dvs_reg, dvs_next;
    logic                 qneg_reg, qneg_next;
    logic                 rneg_reg, rneg_next;
    logic                 byp_reg, byp_next;
    word_t                bq_reg, bq_next;
    word_t                br_reg, br_next;

    logic [WORD_BITS-1:0] mag_a, mag_b;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS-1:0] shifted;

    // Shift-subtract step and special-case capture at start.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        byp_next  = byp_reg;
        bq_next   = bq_reg;
        br_next   = br_reg;
        mag_a     = cmd.dividend[WORD_BITS-1] ? WORD_BITS'(-cmd.dividend) : cmd.dividend;
        mag_b     = cmd.divisor[WORD_BITS-1] ? WORD_BITS'(-cmd.divisor) : cmd.divisor;
        shifted   = {rem_reg[WORD_BITS-2:0], quo_reg[WORD_BITS-1]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(WORD_BITS);
            quo_next  = mag_a;
            rem_next  = '0;
            dvs_next  = mag_b;
            qneg_next = cmd.dividend[WORD_BITS-1] ^ cmd.divisor[WORD_BITS-1];
            rneg_next = cmd.dividend[WORD_BITS-1];
            byp_next  = 1'b0;
            if (cmd.divisor == '0) begin
                byp_next = 1'b1;
                bq_next  = '0;
                br_next  = cmd.dividend;
                cnt_next = '0;
            end else if (cmd.divisor == '1) begin
                byp_next = 1'b1;
                bq_next  = wneg(cmd.dividend);
                br_next  = '0;
                cnt_next = '0;
            end
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
                if (!trial[WORD_BITS]) begin
                    rem_next = trial[WORD_BITS-1:0];
                    quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        byp_reg  <= byp_next;
        bq_reg   <= bq_next;
        br_reg   <= br_next;
    end

    // Apply signs to the magnitudes or hand out the special-case result.
    always_comb begin
        sts.done = done_reg;
        if (byp_reg) begin
            sts.quot = bq_reg;
            sts.rem  = br_reg;
        end else begin
            sts.quot = qneg_reg ? wneg(word_t'(quo_reg)) : word_t'(quo_reg);
            sts.rem  = rneg_reg ? wneg(word_t'(rem_reg)) : word_t'(rem_reg);
        end
    end

endmodule

@@ src/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: adds, subtracts, takes remainders, multiplies,
// inverts and reduces signed fractions, returning a reduced fraction whose
// denominator is positive unless a product wrapped. One request is taken
// at a time; s_ready is low until its result has been taken. Each division
// runs in the shared divider at one quotient bit per cycle, except when the
// divisor is 0 or -1, which it answers without shift-subtract steps, and the
// sequencer adds control states around them. Normalizing x/x or -x/x needs
// no division. Any other reduction runs a gcd loop of one division per
// remainder step and then two more divisions. Add, subtract and remainder
// first run a second gcd loop and three divisions for the common denominator,
// or only two divisions when both denominators are equal. All sums and
// products wrap modulo 2^32, and a zero remainder divisor sets div_error
// with a 0/1 result.
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  req_t  s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output resp_t m_data
);

    state_t   state_reg, state_next;
    gcd_use_t use_reg, use_next;
    req_t     req_reg, req_next;
    word_t    x_reg, x_next;        // gcd / general operand
    word_t    y_reg, y_next;
    word_t    l_reg, l_next;        // common denominator
    word_t    p_reg, p_next;
    word_t    q_reg, q_next;
    word_t    n_reg, n_next;        // fraction under reduction
    word_t    d_reg, d_next;
    word_t    g_reg, g_next;
    logic     stage2_reg, stage2_next;  // second reduction of multiply
    logic     m_valid_reg, m_valid_next;
    resp_t    out_reg, out_next;

    div_cmd_t dcmd;
    div_sts_t dsts;

    rau_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dcmd),
        .sts     (dsts)
    );

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_data.kind inside {KIND_ADD, KIND_SUB, KIND_REM}) begin
                        state_next = ST_LCM_CHK;
                    end else begin
                        state_next = ST_NORM_CHK;
                    end
                end
            end
            ST_LCM_CHK:  state_next = (x_reg == y_reg) ? ST_M1_DIV : ST_GCD_STEP;
            ST_GCD_STEP: begin
                if (y_reg == '0) begin
                    state_next = (use_reg == GCD_FOR_LCM) ? ST_LCM_DIV : ST_NDIV;
                end else begin
                    state_next = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: state_next = dsts.done ? ST_GCD_STEP : ST_GCD_WAIT;
            ST_LCM_DIV:  state_next = ST_LCM_DIVW;
            ST_LCM_DIVW: state_next = dsts.done ? ST_LCM_MUL : ST_LCM_DIVW;
            ST_LCM_MUL:  state_next = ST_M1_DIV;
            ST_M1_DIV:   state_next = ST_M1_DIVW;
            ST_M1_DIVW:  state_next = dsts.done ? ST_M2_DIV : ST_M1_DIVW;
            ST_M2_DIV:   state_next = ST_M2_DIVW;
            ST_M2_DIVW:  state_next = dsts.done ? ST_COMBINE : ST_M2_DIVW;
            ST_COMBINE: begin
                if (req_reg.kind == KIND_REM) begin
                    state_next = (q_reg == '0) ? ST_DONE : ST_REM_DIVW;
                end else begin
                    state_next = ST_NORM_CHK;
                end
            end
            ST_REM_DIVW: state_next = dsts.done ? ST_NORM_CHK : ST_REM_DIVW;
            ST_NORM_CHK: begin
                if (n_reg == d_reg || wneg(n_reg) == d_reg) begin
                    state_next = ST_NFIX;
                end else begin
                    state_next = ST_GCD_STEP;
                end
            end
            ST_NDIV:  state_next = ST_NDIVW;
            ST_NDIVW: state_next = dsts.done ? ST_DDIV : ST_NDIVW;
            ST_DDIV:  state_next = ST_DDIVW;
            ST_DDIVW: state_next = dsts.done ? ST_NFIX : ST_DDIVW;
            ST_NFIX: begin
                state_next = (req_reg.kind == KIND_MUL && !stage2_reg) ? ST_MUL2 : ST_DONE;
            end
            ST_MUL2: state_next = ST_NORM_CHK;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and divider commands.
    always_comb begin
        use_next     = use_reg;
        req_next     = req_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        l_next       = l_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        g_next       = g_reg;
        stage2_next  = stage2_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        dcmd.start    = 1'b0;
        dcmd.dividend = x_reg;
        dcmd.divisor  = y_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next    = s_data;
                    stage2_next = 1'b0;
                    x_next      = s_data.b_den;
                    y_next      = s_data.a_den;
                    l_next      = s_data.b_den;
                    use_next    = GCD_FOR_LCM;
                    case (s_data.kind)
                        KIND_MUL: begin
                            n_next = s_data.a_num;
                            d_next = s_data.b_den;
                        end
                        KIND_IMUL: begin
                            n_next = word_t'(s_data.a_num * s_data.b_num);
                            d_next = s_data.a_den;
                        end
                        KIND_INV: begin
                            if (s_data.a_num == '0) begin
                                n_next = '0;
                                d_next = word_t'(1);
                            end else begin
                                n_next = s_data.a_den;
                                d_next = s_data.a_num;
                            end
                        end
                        default: begin
                            n_next = s_data.a_num;
                            d_next = s_data.a_den;
                        end
                    endcase
                end
            end
            ST_GCD_STEP: begin
                if (y_reg != '0) begin
                    dcmd.start = 1'b1;
                end else begin
                    g_next = x_reg;
                end
            end
            ST_GCD_WAIT: begin
                if (dsts.done) begin
                    x_next = y_reg;
                    y_next = dsts.rem;
                end
            end
            ST_LCM_DIV: begin
                dcmd.start    = 1'b1;
                dcmd.dividend = req_reg.b_den;
                dcmd.divisor  = g_reg;
            end
            ST_LCM_DIVW: if (dsts.done) p_next = dsts.quot;
            ST_LCM_MUL:  l_next = word_t'(p_reg * req_reg.a_den);
            ST_M1_DIV: begin
                dcmd.start    = 1'b1;
                dcmd.dividend = l_reg;
                dcmd.divisor  = req_reg.a_den;
            end
            ST_M1_DIVW: if (dsts.done) p_next = word_t'(req_reg.a_num * dsts.quot);
            ST_M2_DIV: begin
                dcmd.start    = 1'b1;
                dcmd.dividend = l_reg;
                dcmd.divisor  = req_reg.b_den;
            end
            ST_M2_DIVW: if (dsts.done) q_next = word_t'(req_reg.b_num * dsts.quot);
            ST_COMBINE: begin
                d_next = l_reg;
                case (req_reg.kind)
                    KIND_ADD: n_next = word_t'(p_reg + q_reg);
                    KIND_SUB: n_next = word_t'(p_reg - q_reg);
                    default: begin
                        if (q_reg == '0) begin
                            out_next.res_num   = '0;
                            out_next.res_den   = word_t'(1);
                            out_next.div_error = 1'b1;
                        end else begin
                            dcmd.start    = 1'b1;
                            dcmd.dividend = p_reg;
                            dcmd.divisor  = q_reg;
                        end
                    end
                endcase
            end
            ST_REM_DIVW: if (dsts.done) n_next = dsts.rem;
            ST_NORM_CHK: begin
                x_next   = n_reg;
                y_next   = d_reg;
                use_next = GCD_FOR_NORM;
                if (n_reg == d_reg) begin
                    n_next = word_t'(1);
                    d_next = word_t'(1);
                end else if (wneg(n_reg) == d_reg) begin
                    n_next = '1;
                    d_next = word_t'(1);
                end
            end
            ST_NDIV: begin
                dcmd.start    = 1'b1;
                dcmd.dividend = n_reg;
                dcmd.divisor  = g_reg;
            end
            ST_NDIVW: if (dsts.done) n_next = dsts.quot;
            ST_DDIV: begin
                dcmd.start    = 1'b1;
                dcmd.dividend = d_reg;
                dcmd.divisor  = g_reg;
            end
            ST_DDIVW: if (dsts.done) d_next = dsts.quot;
            ST_NFIX: begin
                if (d_reg[WORD_BITS-1]) begin
                    n_next = wneg(n_reg);
                    d_next = wneg(d_reg);
                end
            end
            ST_MUL2: begin
                stage2_next = 1'b1;
                n_next = word_t'(n_reg * req_reg.b_num);
                d_next = word_t'(d_reg * req_reg.a_den);
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                if (!(req_reg.kind == KIND_REM && q_reg == '0)) begin
                    out_next.res_num   = n_reg;
                    out_next.res_den   = d_reg;
                    out_next.div_error = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        use_reg    <= use_next;
        req_reg    <= req_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        l_reg      <= l_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        g_reg      <= g_next;
        stage2_reg <= stage2_next;
        out_reg    <= out_next;
    end

    // A request is taken only while the sequencer is idle with no result pending.
    `RAU_ASSERT_IMPL(a_accept_idle, s_valid && s_ready, state_reg == ST_IDLE && !m_valid_reg, "request taken while busy")
    // A finished sequencer always raises m_valid.
    `RAU_ASSERT_NEXT(a_done_valid, state_reg == ST_DONE, m_valid_reg, "finished request gave no result")
    // A flagged error always carries the fixed 0/1 result.
    `RAU_ASSERT_IMPL(a_err_value, m_valid && m_data.div_error, m_data.res_num == '0 && m_data.res_den == word_t'(1), "error result is not 0/1")

endmodule
